@@ rtl/ees_pkg.sv @@
// shared constants, types and helper functions of the exposure sequencer
package ees_pkg;

    // timing constants in milliseconds
    localparam int TICK_MS         = 10;
    localparam int DMX_PERIOD_MS   = 30;
    localparam int BEEP_LEN_MS     = 40;
    localparam int SECOND_MS       = 1000;
    localparam int HUNDRED_MS      = 100;
    localparam int MAX_EXPOSURE_MS = 1048576;

    // time values are 21 bits wide and saturate at all ones
    localparam int TW = 21;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    // dmx frame slots counted in ticks
    localparam int DMX_SLOTS = DMX_PERIOD_MS / TICK_MS;
    localparam int SLOT_W    = $clog2(DMX_SLOTS);

    // report phase codes
    localparam logic [2:0] PH_NONE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_TICK  = 3'd2;
    localparam logic [2:0] PH_END   = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // report rate codes
    localparam logic [1:0] RATE_TICK   = 2'd0;
    localparam logic [1:0] RATE_100MS  = 2'd1;
    localparam logic [1:0] RATE_SECOND = 2'd2;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_EXPOSURE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ON_DELAY = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_OFF_LEAD = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SETTLE   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_RATE     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_DMX      = 3'd5;

    // inverse of an odd number modulo 2^21, newton iteration
    function automatic logic [TW-1:0] inv_mod(input logic [TW-1:0] d);
        logic [2*TW-1:0] p;
        logic [TW-1:0]   x;
        logic [TW-1:0]   corr;
        x = d;
        for (int i = 0; i < 5; i++)
        begin
            p    = x * d;
            corr = TW'(2) - p[TW-1:0];
            p    = x * corr;
            x    = p[TW-1:0];
        end
        return x;
    endfunction

    // divisibility test constants: x % d == 0 iff (x * inv) mod 2^21 <= lim
    localparam logic [TW-1:0] INV_25  = inv_mod(TW'(25));
    localparam logic [TW-1:0] INV_125 = inv_mod(TW'(125));
    localparam logic [TW-1:0] LIM_25  = TW'((2**TW - 1) / 25);
    localparam logic [TW-1:0] LIM_125 = TW'((2**TW - 1) / 125);

    // reciprocal for exposure % 1000
    localparam int FRAC_SHIFT = 31;
    localparam logic [21:0] FRAC_RECIP = 22'((64'd2**FRAC_SHIFT + 999) / 1000);

    // live configuration
    typedef struct packed {
        logic [TW-1:0] exposure_ms;
        logic [9:0]    exposure_frac;
        logic [15:0]   lamp_on_delay_ms;
        logic [15:0]   lamp_off_lead_ms;
        logic [15:0]   end_settle_ms;
        logic [1:0]    report_rate;
        logic          dmx_mode;
    } cfg_t;

    // result of the state step, before the report rate filter
    typedef struct packed {
        logic          lamp_on;
        logic          lamp_switched_on;
        logic          lamp_switched_off;
        logic          dmx_frame_send;
        logic          buzzer_on;
        logic          notify;
        logic          check;
        logic          per_second;
        logic [2:0]    phase;
        logic [TW-1:0] remaining;
        logic          run_finished;
        logic          config_error;
    } step_t;

endpackage

@@ rtl/ees_step.sv @@
// run state of the sequencer and its one-tick update
module ees_step
    import ees_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  start_run,
    input  logic  cancel,
    input  cfg_t  cfg,
    output step_t res
);

    logic              running_reg, running_next;
    logic [2:0]        phase_reg, phase_next;
    logic [TW-1:0]     elapsed_reg, elapsed_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              act_reg, act_next;
    logic              deact_reg, deact_next;
    logic              off_pend_reg, off_pend_next;
    logic              end_rep_reg, end_rep_next;
    logic              cancel_reg, cancel_next;
    logic [TW-1:0]     beep_start_reg, beep_start_next;
    logic [TW-1:0]     beep_stop_reg, beep_stop_next;
    logic              beeper_reg, beeper_next;

    logic              abort_req;
    logic              last;
    logic              go_on;
    logic              bad_cfg;
    logic [TW:0]       e_sum;
    logic [TW-1:0]     lead_gap;
    logic [TW:0]       off_thr;
    logic [TW:0]       end_thr;
    logic [TW+1:0]     done_thr;
    logic [TW-1:0]     since_on;
    logic [TW-1:0]     remain;
    logic [TW-1:0]     beep_add;

    // saturate a sum to the 21 bit time range
    function automatic logic [TW-1:0] sat(input logic [TW+1:0] v);
        return (v > (TW+2)'(TIME_MAX)) ? TIME_MAX : v[TW-1:0];
    endfunction

    // thresholds from the live configuration
    always_comb
    begin
        lead_gap = (cfg.exposure_ms > TW'(cfg.lamp_off_lead_ms))
                 ? cfg.exposure_ms - TW'(cfg.lamp_off_lead_ms) : '0;
        off_thr  = (TW+1)'(cfg.lamp_on_delay_ms) + (TW+1)'(lead_gap);
        end_thr  = (TW+1)'(cfg.exposure_ms) + (TW+1)'(cfg.lamp_on_delay_ms);
        done_thr = (TW+2)'(end_thr) + (TW+2)'(cfg.end_settle_ms);
        bad_cfg  = (cfg.exposure_ms == '0)
                || (cfg.exposure_ms > TW'(MAX_EXPOSURE_MS))
                || (TW'(cfg.lamp_off_lead_ms) >= cfg.exposure_ms);
        beep_add = (cfg.exposure_frac == '0) ? TW'(SECOND_MS) : TW'(cfg.exposure_frac);
    end

    // one tick of the sequencer
    always_comb
    begin
        running_next    = running_reg;
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        slot_next       = slot_reg;
        act_next        = act_reg;
        deact_next      = deact_reg;
        off_pend_next   = off_pend_reg;
        end_rep_next    = end_rep_reg;
        cancel_next     = cancel_reg;
        beep_start_next = beep_start_reg;
        beep_stop_next  = beep_stop_reg;
        beeper_next     = beeper_reg;
        res             = '0;
        abort_req       = 1'b0;
        last            = 1'b0;
        go_on           = 1'b0;
        e_sum           = '0;
        since_on        = '0;
        remain          = '0;

        // start request and validation
        if (start_run)
        begin
            if (bad_cfg)
            begin
                res.config_error = 1'b1;
            end
            else
            begin
                running_next    = 1'b1;
                act_next        = 1'b0;
                deact_next      = 1'b0;
                off_pend_next   = 1'b0;
                end_rep_next    = 1'b0;
                cancel_next     = 1'b0;
                phase_next      = PH_NONE;
                elapsed_next    = '0;
                slot_next       = '0;
                beep_start_next = '0;
                beep_stop_next  = '0;
                beeper_next     = 1'b0;
            end
        end
        if (cancel)
        begin
            cancel_next = 1'b1;
        end

        if (running_next)
        begin
            abort_req = cancel_next;
            last      = (phase_next == PH_DONE);

            // lamp control and dmx frame slots
            if (!act_next)
            begin
                act_next             = 1'b1;
                res.lamp_switched_on = 1'b1;
                res.dmx_frame_send   = cfg.dmx_mode;
            end
            else
            begin
                e_sum = (TW+1)'(elapsed_next) + (TW+1)'(TICK_MS);
                if (e_sum > (TW+1)'(TIME_MAX))
                begin
                    elapsed_next = TIME_MAX;
                end
                else
                begin
                    elapsed_next = e_sum[TW-1:0];
                    slot_next = (slot_next == SLOT_W'(DMX_SLOTS - 1))
                              ? '0 : slot_next + SLOT_W'(1);
                end
                if (!deact_next && !off_pend_next &&
                    (((TW+1)'(elapsed_next) >= off_thr) || abort_req))
                begin
                    if (cfg.dmx_mode)
                    begin
                        off_pend_next = 1'b1;
                    end
                    else
                    begin
                        deact_next            = 1'b1;
                        res.lamp_switched_off = 1'b1;
                    end
                end
                if (off_pend_next && !cfg.dmx_mode)
                begin
                    off_pend_next         = 1'b0;
                    deact_next            = 1'b1;
                    res.lamp_switched_off = 1'b1;
                end
                if (cfg.dmx_mode && (elapsed_next != TIME_MAX) && (slot_next == '0))
                begin
                    res.dmx_frame_send = 1'b1;
                    if (off_pend_next)
                    begin
                        off_pend_next         = 1'b0;
                        deact_next            = 1'b1;
                        res.lamp_switched_off = 1'b1;
                    end
                end
            end

            // visible start after the on delay
            go_on = 1'b1;
            if (phase_next == PH_NONE)
            begin
                if (elapsed_next >= TW'(cfg.lamp_on_delay_ms))
                begin
                    phase_next      = PH_START;
                    beep_start_next = sat((TW+2)'(elapsed_next) + (TW+2)'(beep_add));
                    beep_stop_next  = '0;
                end
                else
                begin
                    go_on = 1'b0;
                end
            end

            if (go_on)
            begin
                // exposure end
                if (((phase_next == PH_START) || (phase_next == PH_TICK)) &&
                    (((TW+1)'(elapsed_next) >= end_thr) || abort_req))
                begin
                    phase_next = PH_END;
                end

                // second-aligned beep
                if ((beep_start_next != '0) && (elapsed_next >= beep_start_next))
                begin
                    beeper_next    = 1'b1;
                    beep_stop_next = sat((TW+2)'(beep_start_next) + (TW+2)'(BEEP_LEN_MS));
                    if ((phase_next == PH_START) || (phase_next == PH_TICK))
                    begin
                        beep_start_next = sat((TW+2)'(beep_start_next) + (TW+2)'(SECOND_MS));
                    end
                    else
                    begin
                        beep_start_next = '0;
                    end
                end
                else if ((beep_stop_next != '0) && (elapsed_next >= beep_stop_next))
                begin
                    beeper_next    = 1'b0;
                    beep_stop_next = '0;
                end

                // remaining time and report selection
                since_on = (elapsed_next > TW'(cfg.lamp_on_delay_ms))
                         ? elapsed_next - TW'(cfg.lamp_on_delay_ms) : '0;
                case (phase_next)
                    PH_START: remain = cfg.exposure_ms;
                    PH_TICK:  remain = (cfg.exposure_ms > since_on)
                                     ? cfg.exposure_ms - since_on : '0;
                    default:  remain = '0;
                endcase
                res.phase     = phase_next;
                res.remaining = remain;
                case (phase_next)
                    PH_TICK:
                    begin
                        res.notify     = (cfg.report_rate == RATE_TICK);
                        res.check      = (cfg.report_rate != RATE_TICK);
                        res.per_second = (cfg.report_rate != RATE_100MS);
                    end
                    PH_END:
                    begin
                        res.notify   = !end_rep_next;
                        end_rep_next = 1'b1;
                    end
                    default:
                    begin
                        res.notify = 1'b1;
                    end
                endcase

                // phase advance
                if (phase_next == PH_START)
                begin
                    phase_next = PH_TICK;
                end
                else if ((phase_next == PH_END) && (beep_stop_next == '0) &&
                         !off_pend_next &&
                         (((TW+2)'(elapsed_next) > done_thr) || abort_req))
                begin
                    phase_next = PH_DONE;
                end

                if (last)
                begin
                    running_next     = 1'b0;
                    res.run_finished = 1'b1;
                end
            end
        end

        res.lamp_on   = act_next && !deact_next;
        res.buzzer_on = beeper_next;
    end

    // run state control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            phase_reg      <= PH_NONE;
            elapsed_reg    <= '0;
            slot_reg       <= '0;
            act_reg        <= 1'b0;
            deact_reg      <= 1'b0;
            off_pend_reg   <= 1'b0;
            end_rep_reg    <= 1'b0;
            cancel_reg     <= 1'b0;
            beep_start_reg <= '0;
            beep_stop_reg  <= '0;
            beeper_reg     <= 1'b0;
        end
        else if (step)
        begin
            running_reg    <= running_next;
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            slot_reg       <= slot_next;
            act_reg        <= act_next;
            deact_reg      <= deact_next;
            off_pend_reg   <= off_pend_next;
            end_rep_reg    <= end_rep_next;
            cancel_reg     <= cancel_next;
            beep_start_reg <= beep_start_next;
            beep_stop_reg  <= beep_stop_next;
            beeper_reg     <= beeper_next;
        end
    end

endmodule

@@ rtl/enlarger_exposure_sequencer.sv @@
// top level of the enlarger exposure sequencer: config registers, item pipeline
// Each input item is one 10 ms tick and yields exactly one result item. A tick
// is taken in every cycle while the output side keeps up; its result item passes
// the stage one register, which takes the run state update at the accepting
// edge, and then the result register, which takes the report rate filter on the
// remaining time. The input stalls only while a result item waits at the
// output. Configuration writes are always ready and apply to ticks accepted
// after the write.
module enlarger_exposure_sequencer
    import ees_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // tick items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // start_run, cancel, zero fill
    // result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // lamp_on, lamp_switched_on,
                                              // lamp_switched_off, dmx_frame_send,
                                              // buzzer_on, report_valid,
                                              // report_phase[2:0],
                                              // report_remaining_ms[20:0],
                                              // run_finished, config_error
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [TW-1:0]     cfg_data
);

    cfg_t              cfg_reg;
    step_t             step_res;
    step_t             s1_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;
    logic              advance;
    logic              accept;

    logic [42:0]       frac_prod;
    logic [11:0]       frac_q;
    logic [21:0]       frac_r;
    logic [9:0]        frac_val;

    logic [TW-1:0]     chk_op;
    logic [TW-1:0]     chk_inv;
    logic [TW-1:0]     chk_lim;
    logic              chk_low;
    logic [2*TW-1:0]   chk_prod;
    logic              divisible;
    logic              report_valid;

    // exposure % 1000 via reciprocal, off the tick path
    always_comb
    begin
        frac_prod = 43'(cfg_data) * 43'(FRAC_RECIP);
        frac_q    = frac_prod[FRAC_SHIFT +: 12];
        frac_r    = 22'(cfg_data) - 22'({frac_q, 10'b0})
                  + 22'({frac_q, 4'b0}) + 22'({frac_q, 3'b0});
        frac_val  = (frac_r >= 22'(SECOND_MS)) ? 10'(frac_r - 22'(SECOND_MS))
                                               : frac_r[9:0];
    end

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exposure_ms      <= '0;
            cfg_reg.exposure_frac    <= '0;
            cfg_reg.lamp_on_delay_ms <= '0;
            cfg_reg.lamp_off_lead_ms <= '0;
            cfg_reg.end_settle_ms    <= '0;
            cfg_reg.report_rate      <= RATE_SECOND;
            cfg_reg.dmx_mode         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EXPOSURE:
                begin
                    cfg_reg.exposure_ms   <= cfg_data;
                    cfg_reg.exposure_frac <= frac_val;
                end
                CFG_ON_DELAY: cfg_reg.lamp_on_delay_ms <= cfg_data[15:0];
                CFG_OFF_LEAD: cfg_reg.lamp_off_lead_ms <= cfg_data[15:0];
                CFG_SETTLE:   cfg_reg.end_settle_ms    <= cfg_data[15:0];
                CFG_RATE:     cfg_reg.report_rate      <= cfg_data[1:0];
                CFG_DMX:      cfg_reg.dmx_mode         <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // pipeline moves whenever the output register is free or being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    ees_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .start_run (s_axis_tdata[0]),
        .cancel    (s_axis_tdata[1]),
        .cfg       (cfg_reg),
        .res       (step_res)
    );

    // stage one register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= step_res;
        end
    end

    // report rate filter: remaining % 100 or % 1000 by inverse multiply
    always_comb
    begin
        if (s1_reg.per_second)
        begin
            chk_op  = s1_reg.remaining >> 3;
            chk_inv = INV_125;
            chk_lim = LIM_125;
            chk_low = (s1_reg.remaining[2:0] == 3'b0);
        end
        else
        begin
            chk_op  = s1_reg.remaining >> 2;
            chk_inv = INV_25;
            chk_lim = LIM_25;
            chk_low = (s1_reg.remaining[1:0] == 2'b0);
        end
        chk_prod     = chk_op * chk_inv;
        divisible    = chk_low && (chk_prod[TW-1:0] <= chk_lim);
        report_valid = s1_reg.notify || (s1_reg.check && divisible);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= {s1_reg.config_error,
                             s1_reg.run_finished,
                             report_valid ? s1_reg.remaining : {TW{1'b0}},
                             report_valid ? s1_reg.phase : PH_NONE,
                             report_valid,
                             s1_reg.buzzer_on,
                             s1_reg.dmx_frame_send,
                             s1_reg.lamp_switched_off,
                             s1_reg.lamp_switched_on,
                             s1_reg.lamp_on};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/ees_checker.sv @@
// port-level checks of the exposure sequencer, bound to the top level
module ees_checker
    import ees_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // no phase or remaining time without a report
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[29:6] == '0)
        else $error("report fields set without report_valid");

    // run end comes with the done report
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[30] |-> m_axis_tdata[5] && m_axis_tdata[8:6] == PH_DONE)
        else $error("run_finished without done report");

    // switch-on leaves the lamp lit and is never paired with switch-off
    a_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && !m_axis_tdata[2])
        else $error("inconsistent lamp switch-on item");

endmodule

bind enlarger_exposure_sequencer ees_checker u_ees_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/exposure_checker.sv @@
// exposure sequencer checker: predicts each result item from the tick items and compares
`timescale 1ns / 100ps

module exposure_checker
    import ees_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // start_run, cancel, zero fill
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [31:0]       m_axis_tdata,   // lamp_on, lamp_switched_on,
                                              // lamp_switched_off, dmx_frame_send,
                                              // buzzer_on, report_valid,
                                              // report_phase[2:0],
                                              // report_remaining_ms[20:0],
                                              // run_finished, config_error
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [TW-1:0]     cfg_data,
    output int                mismatches,
    output int                pending,
    output int                results_checked,
    output int                runs_finished,
    output int                starts_rejected
);

    typedef struct packed {
        logic          lamp_on;
        logic          switched_on;
        logic          switched_off;
        logic          frame_send;
        logic          buzzer_on;
        logic          report_valid;
        logic [2:0]    report_phase;
        logic [TW-1:0] remaining_ms;
        logic          run_finished;
        logic          config_error;
    } tick_result_t;

    // live register copies
    logic [TW-1:0] exposure_cfg;
    logic [15:0]   on_delay_cfg;
    logic [15:0]   off_lead_cfg;
    logic [15:0]   settle_cfg;
    logic [1:0]    rate_cfg;
    logic          dmx_cfg;

    // run state of the sequencer
    bit            running;
    bit            lamp_lit;
    bit            lamp_dropped;
    bit            off_waiting;
    bit            end_told;
    bit            cancel_held;
    bit            beeper;
    logic [2:0]    run_phase;
    logic [TW-1:0] elapsed_ms;
    logic [TW-1:0] beep_due_ms;
    logic [TW-1:0] beep_quiet_ms;

    tick_result_t  expected_results[$];

    function automatic logic [TW-1:0] clamp_time(input longint unsigned v);
        return (v > longint'(TIME_MAX)) ? TIME_MAX : v[TW-1:0];
    endfunction

    function automatic longint unsigned floor_sub(input longint unsigned a,
                                                  input longint unsigned b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    task automatic clear_state();
        exposure_cfg  = '0;
        on_delay_cfg  = '0;
        off_lead_cfg  = '0;
        settle_cfg    = '0;
        rate_cfg      = RATE_SECOND;
        dmx_cfg       = 1'b0;
        running       = 0;
        lamp_lit      = 0;
        lamp_dropped  = 0;
        off_waiting   = 0;
        end_told      = 0;
        cancel_held   = 0;
        beeper        = 0;
        run_phase     = PH_NONE;
        elapsed_ms    = '0;
        beep_due_ms   = '0;
        beep_quiet_ms = '0;
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] sel, input logic [TW-1:0] value);
        case (sel)
            CFG_EXPOSURE: exposure_cfg = value;
            CFG_ON_DELAY: on_delay_cfg = value[15:0];
            CFG_OFF_LEAD: off_lead_cfg = value[15:0];
            CFG_SETTLE:   settle_cfg   = value[15:0];
            CFG_RATE:     rate_cfg     = value[1:0];
            CFG_DMX:      dmx_cfg      = value[0];
            default: ;
        endcase
    endtask

    // advance the sequencer by one 10 ms tick and form its result item
    task automatic advance_tick(input logic start_bit, input logic cancel_bit,
                                output tick_result_t r);
        longint unsigned on_ms;
        longint unsigned ex_ms;
        longint unsigned remain;
        logic [TW-1:0]   frac;
        bit              cancel_now;
        bit              was_done;
        bit              notify;
        r = '0;
        // start request: validate, then clear the run
        if (start_bit)
        begin
            if (exposure_cfg == 0 || exposure_cfg > MAX_EXPOSURE_MS ||
                off_lead_cfg >= exposure_cfg)
            begin
                r.config_error = 1'b1;
                starts_rejected++;
            end
            else
            begin
                running       = 1;
                lamp_lit      = 0;
                lamp_dropped  = 0;
                off_waiting   = 0;
                end_told      = 0;
                cancel_held   = 0;
                run_phase     = PH_NONE;
                elapsed_ms    = '0;
                beep_due_ms   = '0;
                beep_quiet_ms = '0;
                beeper        = 0;
            end
        end
        if (cancel_bit)
            cancel_held = 1;

        if (running)
        begin
            cancel_now = cancel_held;
            was_done   = (run_phase == PH_DONE);
            on_ms      = on_delay_cfg;
            ex_ms      = exposure_cfg;

            // lamp control, with switch-off deferred to a frame slot in dmx mode
            if (!lamp_lit)
            begin
                lamp_lit      = 1;
                r.switched_on = 1'b1;
                if (dmx_cfg)
                    r.frame_send = 1'b1;
            end
            else
            begin
                elapsed_ms = clamp_time(longint'(elapsed_ms) + TICK_MS);
                if (!lamp_dropped && !off_waiting &&
                    (elapsed_ms >= on_ms + floor_sub(ex_ms, off_lead_cfg) || cancel_now))
                begin
                    if (dmx_cfg)
                        off_waiting = 1;
                    else
                    begin
                        lamp_dropped   = 1;
                        r.switched_off = 1'b1;
                    end
                end
                if (off_waiting && !dmx_cfg)
                begin
                    off_waiting    = 0;
                    lamp_dropped   = 1;
                    r.switched_off = 1'b1;
                end
                if (dmx_cfg && (elapsed_ms % DMX_PERIOD_MS) == 0)
                begin
                    r.frame_send = 1'b1;
                    if (off_waiting)
                    begin
                        off_waiting    = 0;
                        lamp_dropped   = 1;
                        r.switched_off = 1'b1;
                    end
                end
            end

            // visible timing begins once the on delay has passed
            if (run_phase == PH_NONE && elapsed_ms >= on_ms)
            begin
                frac          = exposure_cfg % SECOND_MS;
                run_phase     = PH_START;
                beep_due_ms   = clamp_time(longint'(elapsed_ms) +
                                           ((frac == 0) ? SECOND_MS : frac));
                beep_quiet_ms = '0;
            end

            if (run_phase != PH_NONE)
            begin
                if ((run_phase == PH_START || run_phase == PH_TICK) &&
                    (elapsed_ms >= ex_ms + on_ms || cancel_now))
                    run_phase = PH_END;

                // second-aligned beep
                if (beep_due_ms != 0 && elapsed_ms >= beep_due_ms)
                begin
                    beeper        = 1;
                    beep_quiet_ms = clamp_time(longint'(beep_due_ms) + BEEP_LEN_MS);
                    if (run_phase == PH_START || run_phase == PH_TICK)
                        beep_due_ms = clamp_time(longint'(beep_due_ms) + SECOND_MS);
                    else
                        beep_due_ms = '0;
                end
                else if (beep_quiet_ms != 0 && elapsed_ms >= beep_quiet_ms)
                begin
                    beeper        = 0;
                    beep_quiet_ms = '0;
                end

                // remaining time and throttled notification
                if (run_phase == PH_START)
                    remain = exposure_cfg;
                else if (run_phase == PH_TICK)
                    remain = floor_sub(ex_ms, floor_sub(elapsed_ms, on_ms));
                else
                    remain = 0;

                if (run_phase == PH_TICK)
                begin
                    case (rate_cfg)
                        RATE_TICK:  notify = 1;
                        RATE_100MS: notify = (remain % HUNDRED_MS) == 0;
                        default:    notify = (remain % SECOND_MS) == 0;
                    endcase
                end
                else if (run_phase == PH_END)
                begin
                    notify   = !end_told;
                    end_told = 1;
                end
                else
                    notify = 1;

                if (notify)
                begin
                    r.report_valid = 1'b1;
                    r.report_phase = run_phase;
                    r.remaining_ms = remain[TW-1:0];
                end

                if (run_phase == PH_START)
                    run_phase = PH_TICK;
                else if (run_phase == PH_END && beep_quiet_ms == 0 && !off_waiting &&
                         (elapsed_ms > on_ms + ex_ms + settle_cfg || cancel_now))
                    run_phase = PH_DONE;

                if (was_done)
                begin
                    running        = 0;
                    r.run_finished = 1'b1;
                    runs_finished++;
                end
            end
        end

        r.lamp_on   = lamp_lit && !lamp_dropped;
        r.buzzer_on = beeper;
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] result %0d: %s", $realtime, results_checked, what);
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // compare finished items, then take new ticks and register writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t want;
        tick_result_t got;
        if (!rst_n)
        begin
            clear_state();
            expected_results.delete();
            mismatches      = 0;
            results_checked = 0;
            runs_finished   = 0;
            starts_rejected = 0;
            pending        <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.lamp_on      = m_axis_tdata[0];
                got.switched_on  = m_axis_tdata[1];
                got.switched_off = m_axis_tdata[2];
                got.frame_send   = m_axis_tdata[3];
                got.buzzer_on    = m_axis_tdata[4];
                got.report_valid = m_axis_tdata[5];
                got.report_phase = m_axis_tdata[8:6];
                got.remaining_ms = m_axis_tdata[29:9];
                got.run_finished = m_axis_tdata[30];
                got.config_error = m_axis_tdata[31];
                if (expected_results.size() == 0)
                    flag_mismatch("result item with no tick waiting for it");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("lamp_on", got.lamp_on, want.lamp_on);
                    check_field("lamp_switched_on", got.switched_on, want.switched_on);
                    check_field("lamp_switched_off", got.switched_off, want.switched_off);
                    check_field("dmx_frame_send", got.frame_send, want.frame_send);
                    check_field("buzzer_on", got.buzzer_on, want.buzzer_on);
                    check_field("report_valid", got.report_valid, want.report_valid);
                    check_field("report_phase", got.report_phase, want.report_phase);
                    check_field("report_remaining_ms", got.remaining_ms, want.remaining_ms);
                    check_field("run_finished", got.run_finished, want.run_finished);
                    check_field("config_error", got.config_error, want.config_error);
                end
                results_checked++;
            end
            // a tick taken at the same edge as a write still sees the old registers
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_tick(s_axis_tdata[0], s_axis_tdata[1], want);
                expected_results.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            pending <= expected_results.size();
        end
    end

endmodule

@@ tb/enlarger_exposure_sequencer_test.sv @@
// top of the exposure sequencer testbench: clock, reset, tick and register stimulus, verdict
`timescale 1ns / 100ps

module enlarger_exposure_sequencer_test;
    import ees_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 120;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // start_run, cancel, zero fill
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;   // lamp_on, lamp_switched_on, lamp_switched_off,
                                       // dmx_frame_send, buzzer_on, report_valid,
                                       // report_phase[2:0], report_remaining_ms[20:0],
                                       // run_finished, config_error
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [TW-1:0]     cfg_data;

    int                mismatches;
    int                pending;
    int                results_checked;
    int                runs_finished;
    int                starts_rejected;

    int unsigned       ticks_sent;
    int unsigned       burst_left;
    int unsigned       setting_phases;
    int unsigned       quiet_cycles;
    int unsigned       results_seen;
    bit                hold_done;

    enlarger_exposure_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    exposure_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .runs_finished   (runs_finished),
        .starts_rejected (starts_rejected)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on cycles without any accepted item, plus result count for the receiver
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
        if (m_axis_tvalid && m_axis_tready)
            results_seen <= results_seen + 1;
    end

    // receiver: stall patterns of its own, and one long hold-off while ticks keep coming
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        m_axis_tready = 1'b0;
        hold_done     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 120);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (!hold_done && results_seen >= 400 && s_axis_tvalid)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1;
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ((k % 4) != 3);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one tick item, sent in bursts with random gaps between them
    task automatic send_tick(input bit start_bit, input bit cancel_bit);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, cancel_bit, start_bit};
        do @(posedge clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // stop sending and wait until every expected result has come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input int exposure, input int on_delay, input int off_lead,
                                 input int settle, input int rate, input int dmx);
        logic [CFG_IW-1:0] reg_sel [6];
        logic [TW-1:0]     reg_val [6];
        int                i;
        reg_sel = '{CFG_EXPOSURE, CFG_ON_DELAY, CFG_OFF_LEAD, CFG_SETTLE, CFG_RATE, CFG_DMX};
        reg_val = '{TW'(exposure), TW'(on_delay), TW'(off_lead), TW'(settle), TW'(rate),
                    TW'(dmx)};
        for (i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_sel[i];
            cfg_data  <= reg_val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        setting_phases++;
    endtask

    // directed: rejected starts, extreme registers, cancel while idle, a short full run
    task automatic run_directed();
        int i;
        send_tick(1, 0);
        send_tick(0, 1);
        send_tick(0, 0);
        wait_idle();
        load_settings(int'(TIME_MAX), 0, 0, 0, RATE_TICK, 0);
        send_tick(1, 0);
        wait_idle();
        load_settings(MAX_EXPOSURE_MS + 1, 0, 0, 0, RATE_TICK, 0);
        send_tick(1, 0);
        wait_idle();
        load_settings(50, 0, 50, 0, RATE_TICK, 0);
        send_tick(1, 0);
        wait_idle();
        load_settings(MAX_EXPOSURE_MS, 65535, 65535, 65535, 3, 1);
        send_tick(1, 0);
        send_tick(0, 0);
        send_tick(0, 1);
        for (i = 0; i < 4; i++)
            send_tick(0, 0);
        wait_idle();
        load_settings(30, 0, 0, 0, RATE_TICK, 0);
        send_tick(1, 0);
        for (i = 0; i < 10; i++)
            send_tick(0, 0);
    endtask

    // random settings followed by one run: clean, cancelled, restarted, noisy,
    // continued without start, or with dmx mode flipped around the lamp switch-off
    task automatic random_phase();
        int  exposure;
        int  on_delay;
        int  off_lead;
        int  settle;
        int  rate;
        int  dmx;
        int  pick;
        int  lead_cap;
        int  span;
        int  flavor;
        int  cut;
        int  k;
        bit  start_bit;
        bit  cancel_bit;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            exposure = $urandom_range(0, 1) ? 0 :
                       $urandom_range(MAX_EXPOSURE_MS + 1, int'(TIME_MAX));
        else if (pick < 4)
            exposure = $urandom_range(1, 300);
        else if (pick < 16)
            exposure = 10 * $urandom_range(1, 80);
        else
            exposure = 10 * $urandom_range(81, 300);
        on_delay = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 250);
        lead_cap = (exposure == 0) ? 0 : ((exposure - 1 > 400) ? 400 : exposure - 1);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            off_lead = 0;
        else if (pick == 1)
            off_lead = (exposure + 20 > 65535) ? 65535 : exposure + $urandom_range(0, 20);
        else
            off_lead = $urandom_range(0, lead_cap);
        settle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 250);
        rate   = $urandom_range(0, 3);
        dmx    = $urandom_range(0, 1);
        flavor = $urandom_range(0, 11);
        if (flavor == 11)
            dmx = 1;

        span = (on_delay + ((exposure > 3000) ? 0 : exposure) + settle) / 10 +
               $urandom_range(6, 12);
        if (flavor == 10)
            span = $urandom_range(3, 15);
        cut = $urandom_range(1, span - 1);
        if (flavor == 11)
        begin
            cut = (on_delay + exposure - off_lead) / 10 + $urandom_range(0, 3);
            if (cut >= span)
                cut = span - 1;
            if (cut < 1)
                cut = 1;
        end

        wait_idle();
        load_settings(exposure, on_delay, off_lead, settle, rate, dmx);
        for (k = 0; k < span; k++)
        begin
            if (flavor == 11 && k == cut)
            begin
                wait_idle();
                load_settings(exposure, on_delay, off_lead, $urandom_range(0, 100), rate, 0);
            end
            start_bit  = (k == 0 && flavor != 10) || (flavor == 8 && k == cut) ||
                         (flavor == 9 && $urandom_range(0, 19) == 0);
            cancel_bit = (flavor == 7 && k == cut) ||
                         (flavor == 9 && $urandom_range(0, 14) == 0) ||
                         (flavor == 10 && $urandom_range(0, 9) == 0);
            send_tick(start_bit, cancel_bit);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_EXPOSURE;
        cfg_data       = '0;
        ticks_sent     = 0;
        burst_left     = 0;
        setting_phases = 0;
        rst_n          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        while (ticks_sent < ITEM_TARGET)
            random_phase();
        wait_idle();
        repeat (8) @(posedge clk);

        $display("run covered %0d ticks over %0d register settings: %0d results compared",
                 ticks_sent, setting_phases, results_checked);
        $display("%0d runs reached done, %0d starts rejected, long output hold-off %s",
                 runs_finished, starts_rejected, hold_done ? "applied" : "not reached");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
